>>> rtl/core/ffpa_pkg.sv
// Package: shared types and constants for the first-fit page allocator.
package ffpa_pkg;

    localparam int unsigned ADDR_W  = 32;
    localparam int unsigned IDX_W   = 10;
    localparam int unsigned CNT_W   = 11;
    localparam int unsigned CFG_W   = 32;
    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDRESS   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ENTRIES_IN_USE = 1'b1;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_CLEAR = 1'b1;

    // Map entry bits: taken, first of run, has next.
    localparam logic [2:0] MARK_TAKEN = 3'b001;
    localparam logic [2:0] MARK_FIRST = 3'b010;
    localparam logic [2:0] MARK_NEXT  = 3'b100;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MARK,
        ST_DONE
    } ctl_state_t;

    // Command broadcast from the controller to every cell.
    typedef struct packed {
        logic clear;   // free every entry
        logic shift;   // rotate entries one place toward cell zero
    } cell_cmd_t;

    typedef struct packed {
        logic [ADDR_W-1:0] request_bytes;
        logic              func;
    } req_t;

    typedef struct packed {
        logic              granted;
        logic [IDX_W-1:0]  start_index;
        logic [ADDR_W-1:0] grant_address;
        logic [CNT_W-1:0]  pages_taken;
    } rsp_t;

endpackage

>>> rtl/core/ffpa_if.sv
// Interface: valid/ready channel carrying one payload beat.
interface ffpa_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/core/first_fit_page_allocator.sv
// Top level: first-fit page allocator built on a rotating chain of map cells.
//
//  channel | dir | handshake      | payload
//  --------+-----+----------------+--------------------------------------------
//  req     | in  | valid / ready  | func, request_bytes
//  rsp     | out | valid / ready  | granted, start_index, grant_address,
//          |     |                | pages_taken
//  cfg     | in  | cfg_we         | cfg_index, cfg_data
//
// The map sits in a ring of MAX_PAGES cells. Each cycle of a scan or mark
// pass rotates the ring by one place, so cell zero sees every entry in turn.
// A granted allocate makes one full rotation to find the run and one full
// rotation to write the marks. A failed search makes only the scan rotation;
// a clear or an oversize request goes straight to the done state.
// Reset frees all entries. A pending result holds in the output register and
// blocks the input; the next request is taken only once the register drains.
module first_fit_page_allocator
    import ffpa_pkg::*;
#(
    parameter int unsigned MAX_PAGES  = 1024,
    parameter int unsigned PAGE_BYTES = 4096
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    ffpa_if.sink                 req,
    ffpa_if.source               rsp,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);
    localparam int unsigned PW    = $clog2(MAX_PAGES);
    localparam int unsigned PCW   = $clog2(MAX_PAGES + 1);
    localparam int unsigned SHIFT = $clog2(PAGE_BYTES);
    localparam int unsigned QW    = ADDR_W - SHIFT + 1;

    // configuration
    logic [ADDR_W-1:0] base_reg;
    logic [CNT_W-1:0]  use_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= '0;
            use_reg  <= CNT_W'(1024);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_BASE_ADDRESS:   base_reg <= cfg_data;
                REG_ENTRIES_IN_USE: use_reg  <= cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // ring of cells
    cell_cmd_t  cmd;
    logic [2:0] ent [MAX_PAGES];
    logic       load_mark;
    logic [2:0] mark_val;

    for (genvar g = 0; g < MAX_PAGES; g++)
    begin : g_cell
        ffpa_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cmd       (cmd),
            .from_next ((g == MAX_PAGES-1) ? ent[0] : ent[(g+1) % MAX_PAGES]),
            .load_mark ((g == MAX_PAGES-1) ? load_mark : 1'b0),
            .mark_val  (mark_val),
            .entry     (ent[g])
        );
    end

    // control
    ctl_state_t        state_reg, state_next;
    logic [PCW-1:0]    pos_reg, pos_next;      // index at cell zero, 0..MAX_PAGES-1
    logic [PCW-1:0]    run_reg, run_next;
    logic [PCW-1:0]    need_reg, need_next;
    logic [PCW-1:0]    limit_reg, limit_next;
    logic [PW-1:0]     start_reg, start_next;
    logic              found_reg, found_next;
    rsp_t              out_reg, out_next;
    logic              out_vld_reg, out_vld_next;

    // page count: ceil(bytes / PAGE_BYTES), at least one, capped at MAX_PAGES
    logic [QW-1:0]  q_full;
    logic           need_big;
    logic [PCW-1:0] need_calc;
    always_comb
    begin
        q_full = QW'(req.data.request_bytes >> SHIFT)
               + QW'(|req.data.request_bytes[SHIFT-1:0]);
        if (q_full == '0)
            q_full = QW'(1);
        need_big  = (q_full > QW'(MAX_PAGES));
        need_calc = need_big ? PCW'(MAX_PAGES) : PCW'(q_full);
    end

    logic [PCW-1:0] lim_calc;
    assign lim_calc = (use_reg > CNT_W'(MAX_PAGES)) ? PCW'(MAX_PAGES) : PCW'(use_reg);

    logic in_run;
    assign in_run = ({1'b0, pos_reg} >= {1'b0, PCW'(start_reg)})
                 && ({1'b0, pos_reg} < ({1'b0, PCW'(start_reg)} + {1'b0, need_reg}));

    always_comb
    begin
        state_next   = state_reg;
        pos_next     = pos_reg;
        run_next     = run_reg;
        need_next    = need_reg;
        limit_next   = limit_reg;
        start_next   = start_reg;
        found_next   = found_reg;
        out_next     = out_reg;
        out_vld_next = out_vld_reg;
        cmd          = '0;
        load_mark    = 1'b0;
        mark_val     = ent[0];
        req.ready    = 1'b0;

        if (out_vld_reg && rsp.ready)
            out_vld_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                req.ready = !out_vld_reg;
                if (req.valid && !out_vld_reg)
                begin
                    out_next   = '0;
                    pos_next   = '0;
                    run_next   = '0;
                    found_next = 1'b0;
                    start_next = '0;
                    need_next  = need_calc;
                    limit_next = lim_calc;
                    if (req.data.func == FUNC_CLEAR)
                    begin
                        cmd.clear  = 1'b1;
                        state_next = ST_DONE;
                    end
                    else if (need_big || ({1'b0, need_calc} > {1'b0, lim_calc}))
                        state_next = ST_DONE;
                    else
                        state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                // look at entry pos_reg, then rotate
                cmd.shift = 1'b1;
                if (!found_reg && (pos_reg < limit_reg))
                begin
                    if (ent[0] != '0)
                        run_next = '0;
                    else
                    begin
                        run_next = run_reg + PCW'(1);
                        if (run_next == need_reg)
                        begin
                            found_next = 1'b1;
                            start_next = PW'(pos_reg + PCW'(1) - need_reg);
                        end
                    end
                end
                pos_next = pos_reg + PCW'(1);
                if (pos_reg == PCW'(MAX_PAGES - 1))
                begin
                    pos_next   = '0;
                    state_next = found_next ? ST_MARK : ST_DONE;
                end
            end
            ST_MARK:
            begin
                cmd.shift = 1'b1;
                if (in_run)
                begin
                    load_mark = 1'b1;
                    mark_val  = MARK_TAKEN;
                    if ({1'b0, pos_reg} == {1'b0, PCW'(start_reg)})
                        mark_val = mark_val | MARK_FIRST;
                    if (({1'b0, pos_reg} + 1'b1) < ({1'b0, PCW'(start_reg)} + {1'b0, need_reg}))
                        mark_val = mark_val | MARK_NEXT;
                end
                pos_next = pos_reg + PCW'(1);
                if (pos_reg == PCW'(MAX_PAGES - 1))
                begin
                    out_next.granted       = 1'b1;
                    out_next.start_index   = IDX_W'(start_reg);
                    out_next.grant_address = base_reg
                        + ADDR_W'({{(ADDR_W){1'b0}}, start_reg} << SHIFT);
                    out_next.pages_taken   = CNT_W'(need_reg);
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                out_vld_next = 1'b1;
                state_next   = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            out_vld_reg <= 1'b0;
            pos_reg     <= '0;
            found_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            out_vld_reg <= out_vld_next;
            pos_reg     <= pos_next;
            found_reg   <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        run_reg   <= run_next;
        need_reg  <= need_next;
        limit_reg <= limit_next;
        start_reg <= start_next;
        out_reg   <= out_next;
    end

    assign rsp.valid = out_vld_reg;
    assign rsp.data  = out_reg;
endmodule

>>> rtl/core/ffpa_cell.sv
// Module: one map entry of the rotating page chain.
module ffpa_cell
    import ffpa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_cmd_t  cmd,
    input  logic [2:0] from_next,
    input  logic       load_mark,
    input  logic [2:0] mark_val,
    output logic [2:0] entry
);
    logic [2:0] entry_reg;
    logic [2:0] entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        if (cmd.clear)
            entry_next = '0;
        else if (cmd.shift)
            entry_next = load_mark ? mark_val : from_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            entry_reg <= '0;
        else
            entry_reg <= entry_next;
    end

    assign entry = entry_reg;
endmodule
